// ===== hw/rtl/rv64d_pkg.sv =====
// Shared types, opcode constants and mnemonic tables for the RV64 decoder.
package rv64d_pkg;

  localparam logic [6:0] NoMnem = 7'd127;

  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpFp     = 7'h53;
  localparam logic [6:0] OpReg32  = 7'h3B;
  localparam logic [6:0] OpAmo    = 7'h2F;
  localparam logic [6:0] OpFload  = 7'h07;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpImm32  = 7'h1B;
  localparam logic [6:0] OpFence  = 7'h0F;
  localparam logic [6:0] OpSystem = 7'h73;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpFstore = 7'h27;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpJal    = 7'h6F;
  localparam logic [6:0] OpFmadd  = 7'h43;
  localparam logic [6:0] OpFmsub  = 7'h47;
  localparam logic [6:0] OpFnmsub = 7'h4B;
  localparam logic [6:0] OpFnmadd = 7'h4F;

  // Decoded fields of one result, without the offset.
  typedef struct packed {
    logic        is_compressed;
    logic        is_illegal;
    logic [6:0]  mnemonic;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [4:0]  src3_reg;
    logic [31:0] immediate;
    logic [11:0] csr_number;
    logic [7:0]  fence_bits;
    logic [1:0]  acquire_release;
  } dec_result_t;

  // Row select for the register-register tables by funct7.
  function automatic logic [1:0] f7_row(input logic [6:0] f7);
    if (f7 == 7'h00) return 2'd0;
    if (f7 == 7'h20) return 2'd1;
    if (f7 == 7'h01) return 2'd2;
    return 2'd3;
  endfunction

  function automatic logic [6:0] op_tab(input logic [1:0] row, input logic [2:0] f3);
    logic [6:0] m;
    m = NoMnem;
    case (row)
      2'd0: case (f3)
        3'd0: m = 7'd0; 3'd1: m = 7'd2; 3'd2: m = 7'd3; 3'd3: m = 7'd4;
        3'd4: m = 7'd5; 3'd5: m = 7'd6; 3'd6: m = 7'd8; default: m = 7'd9;
      endcase
      2'd1: m = (f3 == 3'd0) ? 7'd1 : (f3 == 3'd5) ? 7'd7 : NoMnem;
      2'd2: m = 7'd10 + {4'd0, f3};
      default: m = NoMnem;
    endcase
    return m;
  endfunction

  function automatic logic [6:0] op32_tab(input logic [1:0] row, input logic [2:0] f3);
    logic [6:0] m;
    m = NoMnem;
    case (row)
      2'd0: m = (f3 == 3'd0) ? 7'd52 : (f3 == 3'd1) ? 7'd54 :
                (f3 == 3'd5) ? 7'd55 : NoMnem;
      2'd1: m = (f3 == 3'd0) ? 7'd53 : (f3 == 3'd5) ? 7'd56 : NoMnem;
      2'd2: case (f3)
        3'd0: m = 7'd57; 3'd4: m = 7'd58; 3'd5: m = 7'd59;
        3'd6: m = 7'd60; 3'd7: m = 7'd61; default: m = NoMnem;
      endcase
      default: m = NoMnem;
    endcase
    return m;
  endfunction

  function automatic logic [6:0] amo_tab(input logic [4:0] f5);
    logic [6:0] m;
    case (f5)
      5'd0: m = 7'd65; 5'd1: m = 7'd64; 5'd2: m = 7'd62; 5'd3: m = 7'd63;
      5'd4: m = 7'd66; 5'd8: m = 7'd68; 5'd12: m = 7'd67; 5'd16: m = 7'd69;
      5'd20: m = 7'd70; 5'd24: m = 7'd71; 5'd28: m = 7'd72;
      default: m = NoMnem;
    endcase
    return m;
  endfunction

  function automatic logic [6:0] fp_op(input logic [6:0] f7, input logic [2:0] f3,
                                       input logic [4:0] rs2);
    logic [6:0] m;
    m = NoMnem;
    case (f7)
      7'h01: m = 7'd22;
      7'h05: m = 7'd23;
      7'h09: m = 7'd24;
      7'h0D: m = 7'd25;
      7'h2D: m = (rs2 == 5'd0) ? 7'd26 : NoMnem;
      7'h11: m = (f3 == 3'd0) ? 7'd27 : (f3 == 3'd1) ? 7'd28 :
                 (f3 == 3'd2) ? 7'd29 : NoMnem;
      7'h15: m = (f3 == 3'd0) ? 7'd30 : (f3 == 3'd1) ? 7'd31 : NoMnem;
      7'h20: m = (rs2 == 5'd1) ? 7'd32 : NoMnem;
      7'h21: m = (rs2 == 5'd0) ? 7'd33 : NoMnem;
      7'h51: m = (f3 == 3'd2) ? 7'd34 : (f3 == 3'd1) ? 7'd35 :
                 (f3 == 3'd0) ? 7'd36 : NoMnem;
      7'h71: m = (rs2 != 5'd0) ? NoMnem : (f3 == 3'd1) ? 7'd37 :
                 (f3 == 3'd0) ? 7'd38 : NoMnem;
      7'h61: m = (rs2 < 5'd4) ? 7'd39 + {2'd0, rs2} : NoMnem;
      7'h69: m = (rs2 < 5'd4) ? 7'd43 + {2'd0, rs2} : NoMnem;
      7'h60: m = (rs2 == 5'd2 || rs2 == 5'd3) ? 7'd45 + {2'd0, rs2} : NoMnem;
      7'h68: m = (rs2 == 5'd2 || rs2 == 5'd3) ? 7'd47 + {2'd0, rs2} : NoMnem;
      7'h79: m = (rs2 == 5'd0 && f3 == 3'd0) ? 7'd51 : NoMnem;
      default: m = NoMnem;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/rv64_instruction_decoder.sv =====
// Top level of the RV64 decoder: input register, decode, result register.
//
// The decoder takes one 32-bit fetch word per request and returns one result
// per request. A request passes through the input register and then the result
// register, and one request can be taken every cycle while results are taken;
// the output register and the input register stall together only when
// both are full and the result is not taken. The byte offset counter advances
// by 4 for full-length words and by 2 for compressed ones and wraps at
// OFFSET_WIDTH bits; the low 32 bits are reported.
module rv64_instruction_decoder
  import rv64d_pkg::*;
#(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // instruction_word
  output logic         m_tvalid,
  input  logic         m_tready,
  // byte_offset[31:0], is_compressed[32], is_illegal[33], mnemonic[40:34],
  // dest_reg[45:41], src1_reg[50:46], src2_reg[55:51], src3_reg[60:56],
  // immediate[92:61], csr_number[104:93], fence_bits[112:105],
  // acquire_release[114:113], zero fill[119:115]
  output logic [119:0] m_tdata
);

  logic                    in_valid;
  logic [31:0]             in_word;
  logic [31:0]             in_offset;
  logic [OFFSET_WIDTH-1:0] offset_counter;
  logic                    out_valid;
  dec_result_t             dec;
  dec_result_t             out_res;
  logic [31:0]             out_offset;
  logic                    adv_out;
  logic                    adv_in;

  assign adv_out  = !out_valid || m_tready;
  assign adv_in   = !in_valid || adv_out;
  assign s_tready = adv_in;

  // Input stage and running offset.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      offset_counter <= '0;
    end else if (adv_in) begin
      in_valid <= s_tvalid;
      if (s_tvalid) begin
        offset_counter <= offset_counter +
          ((s_tdata[1:0] == 2'b11) ? OFFSET_WIDTH'(4) : OFFSET_WIDTH'(2));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && s_tvalid) begin
      in_word   <= s_tdata;
      in_offset <= 32'(offset_counter);
    end
  end

  rv64d_decode u_decode (
    .word   (in_word),
    .result (dec)
  );

  // Result stage.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv_out) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv_out && in_valid) begin
      out_res    <= dec;
      out_offset <= in_offset;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_res.acquire_release, out_res.fence_bits,
                     out_res.csr_number, out_res.immediate, out_res.src3_reg,
                     out_res.src2_reg, out_res.src1_reg, out_res.dest_reg,
                     out_res.mnemonic, out_res.is_illegal, out_res.is_compressed,
                     out_offset};

  // A stalled result holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> out_valid && $stable(out_offset))
    else $error("result changed while stalled");

  // Illegal and compressed never both flagged.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.is_illegal && out_res.is_compressed))
    else $error("illegal and compressed both set");

  // A flagged item carries no mnemonic.
  a_nomnem: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.is_illegal || out_res.is_compressed)
      |-> out_res.mnemonic == NoMnem)
    else $error("mnemonic on flagged item");

endmodule

// ===== hw/rtl/rv64d_decode.sv =====
// Combinational decode of one 32-bit fetch word into result fields.
module rv64d_decode
  import rv64d_pkg::*;
(
  input  logic [31:0]  word,
  output dec_result_t  result
);

  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rs2;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic        full;

  assign op    = word[6:0];
  assign f3    = word[14:12];
  assign f7    = word[31:25];
  assign rs2   = word[24:20];
  assign full  = (word[1:0] == 2'b11);
  assign imm_i = {{20{word[31]}}, word[31:20]};
  assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
  assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
  assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};

  // Match the opcode and its sub-fields; side fields are cleared unless legal.
  always_comb begin
    logic [6:0]  m;
    logic [31:0] imm;
    logic [11:0] csr;
    logic [7:0]  fb;
    logic [1:0]  ar;
    logic [4:0]  r3;
    m   = NoMnem;
    imm = '0;
    csr = '0;
    fb  = '0;
    ar  = '0;
    r3  = '0;
    unique case (op)
      OpReg:   m = op_tab(f7_row(f7), f3);
      OpFmadd, OpFmsub, OpFnmsub, OpFnmadd: begin
        r3 = word[31:27];
        m  = 7'd18 + {5'd0, op[3:2]};
      end
      OpFp:    m = fp_op(f7, f3, rs2);
      OpReg32: m = op32_tab(f7_row(f7), f3);
      OpAmo: begin
        if (f3 == 3'd3) begin
          m = amo_tab(word[31:27]);
          if (m == 7'd62 && rs2 != 5'd0) m = NoMnem;
          ar = word[26:25];
        end
      end
      OpFload: if (f3 == 3'd2) begin m = 7'd73; imm = imm_i; end
      OpJalr:  if (f3 == 3'd0) begin m = 7'd74; imm = imm_i; end
      OpLoad: begin
        imm = imm_i;
        case (f3)
          3'd0: m = 7'd75; 3'd1: m = 7'd76; 3'd2: m = 7'd77; 3'd3: m = 7'd80;
          3'd4: m = 7'd78; 3'd5: m = 7'd79; 3'd6: m = 7'd81;
          default: m = NoMnem;
        endcase
      end
      OpImm: begin
        if (f3 == 3'd1 || f3 == 3'd5) begin
          imm = {26'd0, word[25:20]};
          if (word[31:26] == 6'd0) m = (f3 == 3'd1) ? 7'd88 : 7'd89;
          else if (word[31:26] == 6'h10 && f3 == 3'd5) m = 7'd90;
        end else begin
          imm = imm_i;
          case (f3)
            3'd0: m = 7'd82; 3'd2: m = 7'd83; 3'd3: m = 7'd84;
            3'd4: m = 7'd85; 3'd6: m = 7'd86; default: m = 7'd87;
          endcase
        end
      end
      OpImm32: begin
        if (f3 == 3'd0) begin
          imm = imm_i;
          m   = 7'd91;
        end else begin
          imm = {27'd0, rs2};
          if (f3 == 3'd1 && f7 == 7'h00) m = 7'd92;
          else if (f3 == 3'd5 && f7 == 7'h00) m = 7'd93;
          else if (f3 == 3'd5 && f7 == 7'h20) m = 7'd94;
        end
      end
      OpFence: begin
        if (f3 == 3'd0) begin m = 7'd95; fb = word[27:20]; end
        else if (f3 == 3'd1) m = 7'd96;
      end
      OpSystem: begin
        if (f3 == 3'd0) begin
          if (word[31:20] == 12'd0) m = 7'd97;
          else if (word[31:20] == 12'd1) m = 7'd98;
        end else if (f3 != 3'd4) begin
          csr = word[31:20];
          if (f3[2]) begin
            // Immediate forms csrrwi, csrrsi, csrrci follow on from csrrc.
            imm = {27'd0, word[19:15]};
            m   = 7'd97 + {4'd0, f3};
          end else begin
            m = 7'd98 + {4'd0, f3};
          end
        end
      end
      OpStore: begin
        imm = imm_s;
        case (f3)
          3'd0: m = 7'd105; 3'd1: m = 7'd106; 3'd2: m = 7'd107; 3'd3: m = 7'd108;
          default: m = NoMnem;
        endcase
      end
      OpFstore: if (f3 == 3'd2) begin m = 7'd109; imm = imm_s; end
      OpBranch: begin
        imm = imm_b;
        case (f3)
          3'd0: m = 7'd110; 3'd1: m = 7'd111; 3'd4: m = 7'd112;
          3'd5: m = 7'd113; 3'd6: m = 7'd114; 3'd7: m = 7'd115;
          default: m = NoMnem;
        endcase
      end
      OpLui:   begin m = 7'd116; imm = {word[31:12], 12'd0}; end
      OpAuipc: begin m = 7'd117; imm = {word[31:12], 12'd0}; end
      OpJal:   begin m = 7'd118; imm = imm_j; end
      default: m = NoMnem;
    endcase

    result = '0;
    result.is_compressed = !full;
    result.mnemonic      = NoMnem;
    if (full) begin
      if (m == NoMnem) begin
        result.is_illegal = 1'b1;
      end else begin
        result.mnemonic        = m;
        result.dest_reg        = word[11:7];
        result.src1_reg        = word[19:15];
        result.src2_reg        = rs2;
        result.src3_reg        = r3;
        result.immediate       = imm;
        result.csr_number      = csr;
        result.fence_bits      = fb;
        result.acquire_release = ar;
      end
    end
  end

endmodule
